### hw/rtl/oate_pkg.sv
// Shared types and constants for the ordered array table engine.
// Holds the command, status and cell control codes; depends on nothing else.
package oate_pkg;

   localparam int CAPACITY = 32;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_UPDATE  = 3'd3,
      OP_SEARCH  = 3'd4,
      OP_SORT    = 3'd5,
      OP_REVERSE = 3'd6,
      OP_READ    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_BADPOS   = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_NOTFOUND = 3'd3,
      STATUS_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_UPDATE,
      CELL_ROTATE,
      CELL_EXCHANGE
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type              cmd;
      logic [COUNT_W-1:0]        pos;
      logic signed [DATA_W-1:0]  value;
      logic [COUNT_W-1:0]        count;
      logic                      phase;
      logic                      desc;
      logic                      force_swap;
   } cell_ctrl_type;

endpackage

### hw/rtl/ordered_array_table_engine.sv
// Ordered array table engine: a row of cells under one command sequencer.
// Clear, insert, delete and update complete when taken; the response is registered and shows in the next cycle.
// Search and read both rotate the whole row once around past cell 0; read responses
// stream one per cycle. Sort and reverse run count odd-even exchange rounds, one a cycle.
// A request is taken whenever busy is low, also while a response is on the outputs.
// Reset clears the element count and the sequencer; cell contents are kept as they are.
module ordered_array_table_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_operation,
   input  logic [oate_pkg::POS_W-1:0]          req_position,
   input  logic signed [oate_pkg::DATA_W-1:0]  req_value,
   input  logic                                req_descending,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [oate_pkg::POS_W-1:0]          rsp_found_index,
   output logic signed [oate_pkg::DATA_W-1:0]  rsp_element,
   output logic [oate_pkg::COUNT_W-1:0]        rsp_element_count,
   output logic                                rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NET
   } state_type;

   localparam logic [oate_pkg::COUNT_W-1:0] LAST_SCAN = oate_pkg::COUNT_W'(oate_pkg::CAPACITY - 1);
   localparam logic [oate_pkg::COUNT_W-1:0] CAP_COUNT = oate_pkg::COUNT_W'(oate_pkg::CAPACITY);

   state_type                          state_ff;
   logic [oate_pkg::COUNT_W-1:0]       count_ff;
   logic [oate_pkg::COUNT_W-1:0]       step_ff;
   logic signed [oate_pkg::DATA_W-1:0] key_ff;
   logic                               read_mode_ff;
   logic                               found_ff;
   logic [oate_pkg::POS_W-1:0]         hit_ff;
   logic                               desc_ff;
   logic                               force_ff;

   logic                               rsp_valid_ff;
   oate_pkg::status_type               rsp_status_ff;
   logic [oate_pkg::POS_W-1:0]         rsp_index_ff;
   logic signed [oate_pkg::DATA_W-1:0] rsp_element_ff;
   logic [oate_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic                               rsp_last_ff;

   oate_pkg::cell_ctrl_type            ctrl;
   oate_pkg::op_type                   op;
   logic signed [oate_pkg::DATA_W-1:0] cell_q [oate_pkg::CAPACITY];
   logic [oate_pkg::COUNT_W-1:0]       pos_ext;
   logic                               accept;
   logic                               pos_above_count;
   logic                               pos_in_range;
   logic                               match;

   assign op              = oate_pkg::op_type'(req_operation);
   assign accept          = start && (state_ff == ST_IDLE);
   assign pos_ext         = {1'b0, req_position};
   assign pos_above_count = pos_ext > count_ff;
   assign pos_in_range    = pos_ext < count_ff;
   assign match           = (cell_q[0] == key_ff) && (step_ff < count_ff) && !found_ff;

   always_comb begin
      ctrl.cmd        = oate_pkg::CELL_HOLD;
      ctrl.pos        = pos_ext;
      ctrl.value      = req_value;
      ctrl.count      = count_ff;
      ctrl.phase      = step_ff[0];
      ctrl.desc       = desc_ff;
      ctrl.force_swap = force_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == oate_pkg::OP_INSERT && !pos_above_count && count_ff < CAP_COUNT) begin
                  ctrl.cmd = oate_pkg::CELL_INSERT;
               end else if (op == oate_pkg::OP_DELETE && pos_in_range) begin
                  ctrl.cmd = oate_pkg::CELL_DELETE;
               end else if (op == oate_pkg::OP_UPDATE && pos_in_range) begin
                  ctrl.cmd = oate_pkg::CELL_UPDATE;
               end
            end
         end
         ST_SCAN: ctrl.cmd = oate_pkg::CELL_ROTATE;
         ST_NET:  ctrl.cmd = oate_pkg::CELL_EXCHANGE;
         default: ctrl.cmd = oate_pkg::CELL_HOLD;
      endcase
   end

   for (genvar i = 0; i < oate_pkg::CAPACITY; i++) begin : g_cell
      logic signed [oate_pkg::DATA_W-1:0] left_value;
      logic signed [oate_pkg::DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_left
         assign left_value = cell_q[i-1];
      end
      if (i == oate_pkg::CAPACITY - 1) begin : g_wrap
         assign right_value = cell_q[0];
      end else begin : g_mid_right
         assign right_value = cell_q[i+1];
      end

      oate_cell u_cell (
         .clock       (clock),
         .cell_index  (oate_pkg::COUNT_W'(i)),
         .ctrl        (ctrl),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rsp_index_ff   <= '0;
                  rsp_element_ff <= '0;
                  rsp_last_ff    <= 1'b1;
                  rsp_status_ff  <= oate_pkg::STATUS_OK;
                  rsp_count_ff   <= count_ff;
                  unique case (op)
                     oate_pkg::OP_CLEAR: begin
                        count_ff     <= '0;
                        rsp_count_ff <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     oate_pkg::OP_INSERT: begin
                        rsp_valid_ff <= 1'b1;
                        if (pos_above_count) begin
                           rsp_status_ff <= oate_pkg::STATUS_BADPOS;
                        end else if (count_ff >= CAP_COUNT) begin
                           rsp_status_ff <= oate_pkg::STATUS_FULL;
                        end else begin
                           count_ff     <= count_ff + 1'b1;
                           rsp_count_ff <= count_ff + 1'b1;
                        end
                     end
                     oate_pkg::OP_DELETE: begin
                        rsp_valid_ff <= 1'b1;
                        if (!pos_in_range) begin
                           rsp_status_ff <= oate_pkg::STATUS_BADPOS;
                        end else begin
                           count_ff     <= count_ff - 1'b1;
                           rsp_count_ff <= count_ff - 1'b1;
                        end
                     end
                     oate_pkg::OP_UPDATE: begin
                        rsp_valid_ff <= 1'b1;
                        if (!pos_in_range) begin
                           rsp_status_ff <= oate_pkg::STATUS_BADPOS;
                        end
                     end
                     oate_pkg::OP_SEARCH: begin
                        key_ff       <= req_value;
                        step_ff      <= '0;
                        found_ff     <= 1'b0;
                        hit_ff       <= '0;
                        read_mode_ff <= 1'b0;
                        state_ff     <= ST_SCAN;
                     end
                     oate_pkg::OP_SORT, oate_pkg::OP_REVERSE: begin
                        if (count_ff < 2) begin
                           rsp_valid_ff <= 1'b1;
                        end else begin
                           step_ff  <= '0;
                           desc_ff  <= req_descending;
                           force_ff <= (op == oate_pkg::OP_REVERSE);
                           state_ff <= ST_NET;
                        end
                     end
                     oate_pkg::OP_READ: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= oate_pkg::STATUS_EMPTY;
                        end else begin
                           step_ff      <= '0;
                           found_ff     <= 1'b0;
                           hit_ff       <= '0;
                           read_mode_ff <= 1'b1;
                           state_ff     <= ST_SCAN;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (match) begin
                  found_ff <= 1'b1;
                  hit_ff   <= step_ff[oate_pkg::POS_W-1:0];
               end
               if (read_mode_ff && step_ff < count_ff) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= oate_pkg::STATUS_OK;
                  rsp_index_ff   <= step_ff[oate_pkg::POS_W-1:0];
                  rsp_element_ff <= cell_q[0];
                  rsp_count_ff   <= count_ff;
                  rsp_last_ff    <= (step_ff + 1'b1) == count_ff;
               end
               if (step_ff == LAST_SCAN) begin
                  state_ff <= ST_IDLE;
                  if (!read_mode_ff) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_element_ff <= '0;
                     rsp_count_ff   <= count_ff;
                     rsp_last_ff    <= 1'b1;
                     if (found_ff) begin
                        rsp_status_ff <= oate_pkg::STATUS_OK;
                        rsp_index_ff  <= hit_ff;
                     end else if (match) begin
                        rsp_status_ff <= oate_pkg::STATUS_OK;
                        rsp_index_ff  <= step_ff[oate_pkg::POS_W-1:0];
                     end else begin
                        rsp_status_ff <= oate_pkg::STATUS_NOTFOUND;
                        rsp_index_ff  <= '0;
                     end
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_NET: begin
               if ((step_ff + 1'b1) == count_ff) begin
                  state_ff       <= ST_IDLE;
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= oate_pkg::STATUS_OK;
                  rsp_index_ff   <= '0;
                  rsp_element_ff <= '0;
                  rsp_count_ff   <= count_ff;
                  rsp_last_ff    <= 1'b1;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_index_ff;
   assign rsp_element       = rsp_element_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_COUNT)
      else $error("element count exceeds capacity");

   a_net_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NET) |-> !rsp_valid_ff)
      else $error("response shown during an exchange pass");

   a_read_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("read responses are not consecutive");

   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == oate_pkg::STATUS_EMPTY) |->
         (rsp_last_ff && rsp_count_ff == '0))
      else $error("empty response is malformed");

endmodule

### hw/rtl/oate_cell.sv
// One storage cell of the ordered array table engine.
// Holds one element and trades it with its neighbors; uses oate_pkg.
module oate_cell (
   input  logic                                clock,
   input  logic [oate_pkg::COUNT_W-1:0]        cell_index,
   input  oate_pkg::cell_ctrl_type             ctrl,
   input  logic signed [oate_pkg::DATA_W-1:0]  left_value,
   input  logic signed [oate_pkg::DATA_W-1:0]  right_value,
   output logic signed [oate_pkg::DATA_W-1:0]  value
);

   logic signed [oate_pkg::DATA_W-1:0] value_ff;
   logic signed [oate_pkg::DATA_W-1:0] value_in;
   logic signed [oate_pkg::DATA_W-1:0] lo_value;
   logic signed [oate_pkg::DATA_W-1:0] hi_value;
   logic                               lower;
   logic                               lower_active;
   logic                               upper_active;
   logic                               swap;

   always_comb begin
      lower        = (cell_index[0] == ctrl.phase);
      lower_active = lower && ((cell_index + 1'b1) < ctrl.count);
      upper_active = !lower && (cell_index != '0) && (cell_index < ctrl.count);
      lo_value     = lower ? value_ff : left_value;
      hi_value     = lower ? right_value : value_ff;
      swap         = ctrl.force_swap ||
                     (ctrl.desc ? (lo_value < hi_value) : (lo_value > hi_value));
   end

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.cmd)
         oate_pkg::CELL_HOLD: begin
            value_in = value_ff;
         end
         oate_pkg::CELL_INSERT: begin
            if (cell_index > ctrl.pos) begin
               value_in = left_value;
            end else if (cell_index == ctrl.pos) begin
               value_in = ctrl.value;
            end
         end
         oate_pkg::CELL_DELETE: begin
            if (cell_index >= ctrl.pos) begin
               value_in = right_value;
            end
         end
         oate_pkg::CELL_UPDATE: begin
            if (cell_index == ctrl.pos) begin
               value_in = ctrl.value;
            end
         end
         oate_pkg::CELL_ROTATE: begin
            value_in = right_value;
         end
         oate_pkg::CELL_EXCHANGE: begin
            if (lower_active && swap) begin
               value_in = right_value;
            end else if (upper_active && swap) begin
               value_in = left_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
